/* src/btpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package btpc_pkg;

  // Queue between the temperature front end and the pressure back end
  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Back end: seven setup stages, one stage per quotient bit, four post stages
  localparam int DivBits    = 64;
  localparam int SetupStg   = 7;
  localparam int PostStg    = 4;
  localparam int BackStages = SetupStg + DivBits + PostStg;
  localparam int FlagStart  = SetupStg - 1;
  localparam int DivEnd     = SetupStg + DivBits - 1;

  localparam logic signed [31:0] FineOffset = 32'sd128000;
  localparam logic [20:0]        PressBase  = 21'd1048576;
  localparam logic [11:0]        DivScale   = 12'd3125;
  localparam logic [63:0]        Bias47     = 64'h0000_8000_0000_0000;

  typedef enum logic [1:0] {
    CfgTemp     = 2'd0,
    CfgPressLow = 2'd1,
    CfgPressMid = 2'd2,
    CfgPressTop = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [15:0] centi;
  } tinfo_t;

  typedef struct packed {
    tinfo_t      ti;
    logic [19:0] adc_p;
  } tq_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } dflag_t;

endpackage

`default_nettype wire

/* src/btpc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

`default_nettype wire

/* src/btpc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface btpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fine_temperature;
  logic signed [15:0] temperature_centi;
  logic        [31:0] pressure_q24_8;
  logic               divisor_zero;

  modport source (output valid, output fine_temperature, output temperature_centi,
                  output pressure_q24_8, output divisor_zero, input ready);
  modport sink   (input valid, input fine_temperature, input temperature_centi,
                  input pressure_q24_8, input divisor_zero, output ready);
endinterface

`default_nettype wire

/* src/btpc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module btpc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  btpc_in_if.sink             in_bus,
  input  wire btpc_pkg::cal_t cal,
  input  wire logic           q_ready,
  output logic                push,
  output btpc_pkg::tq_t       push_data
);

  logic               adv;
  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [17:0] d1_r;
  logic signed [16:0] d2_r;
  logic        [19:0] ap1_r, ap2_r, ap3_r, ap4_r;
  logic signed [33:0] ta_prod_r;
  logic signed [33:0] sq_r;
  logic signed [22:0] ta_r;
  logic signed [37:0] tb_prod_r;
  logic signed [31:0] fine_r;

  logic signed [17:0] d1_nxt;
  logic signed [16:0] d2_nxt;
  logic signed [31:0] fine_nxt;
  logic signed [35:0] c5;
  logic signed [27:0] ch;
  logic signed [15:0] centi;

  // advance when the last stage is empty or the queue has room
  assign adv          = !v4_r || q_ready;
  assign in_bus.ready = adv;
  assign push         = v4_r && q_ready;

  assign d1_nxt = $signed({1'b0, in_bus.raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign d2_nxt = $signed({1'b0, in_bus.raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
  assign fine_nxt = $signed({{9{ta_r[22]}}, ta_r})
                  + $signed({{8{tb_prod_r[37]}}, tb_prod_r[37:14]});

  // (fine * 5 + 128) >>> 8, then clamp to 16 bits
  assign c5 = $signed({{4{fine_r[31]}}, fine_r} << 2) + $signed({{4{fine_r[31]}}, fine_r})
            + 36'sd128;
  assign ch = c5[35:8];

  always_comb begin
    if (ch > 28'sd32767) begin
      centi = 16'sh7fff;
    end else if (ch < -28'sd32768) begin
      centi = 16'sh8000;
    end else begin
      centi = ch[15:0];
    end
  end

  assign push_data.ti.fine  = fine_r;
  assign push_data.ti.centi = centi;
  assign push_data.adc_p    = ap4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_bus.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r      <= d1_nxt;
      d2_r      <= d2_nxt;
      ap1_r     <= in_bus.raw_pressure;
      ta_prod_r <= d1_r * $signed(cal.t2);
      sq_r      <= d2_r * d2_r;
      ap2_r     <= ap1_r;
      ta_r      <= ta_prod_r[33:11];
      tb_prod_r <= $signed(sq_r[33:12]) * $signed(cal.t3);
      ap3_r     <= ap2_r;
      fine_r    <= fine_nxt;
      ap4_r     <= ap3_r;
    end
  end

endmodule

`default_nettype wire

/* src/btpc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module btpc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire btpc_pkg::tq_t push_data,
  input  wire logic          pop,
  output btpc_pkg::tq_t      pop_data,
  output logic               nonempty,
  output logic               not_full
);

  btpc_pkg::tq_t                    mem_r [btpc_pkg::QDepth];
  logic [btpc_pkg::QAddrW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [btpc_pkg::QCntW-1:0]       cnt_r;

  assign pop_data = mem_r[rd_ptr_r];
  assign nonempty = cnt_r != '0;
  assign not_full = cnt_r != btpc_pkg::QCntW'(btpc_pkg::QDepth);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != btpc_pkg::QCntW'(btpc_pkg::QDepth) || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == btpc_pkg::QCntW'($past(cnt_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

/* src/btpc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module btpc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire btpc_pkg::cal_t cal,
  input  wire logic           q_valid,
  input  wire btpc_pkg::tq_t  q_data,
  output logic                pop,
  btpc_out_if.source          out_bus
);

  logic                                adv;
  logic [btpc_pkg::BackStages-1:0]     v_r;
  btpc_pkg::tinfo_t                    ti_r [btpc_pkg::BackStages];
  btpc_pkg::dflag_t                    fl_r [btpc_pkg::FlagStart:btpc_pkg::BackStages-1];
  btpc_pkg::dflag_t                    fl_nxt;

  // setup stages
  logic signed [31:0] xw;
  logic signed [23:0] x1_r;
  logic        [20:0] pn1_r, pn2_r, pn3_r, pn4_r;
  logic signed [47:0] xx2_r;
  logic signed [39:0] xp5_2_r, xp2_2_r, xp5_3_r, xp2_3_r;
  logic signed [63:0] y6_3_r, x3_3_r;
  logic        [63:0] y4_r, s4_r;
  logic signed [63:0] vprod;
  logic signed [30:0] dv5_r, dv6_r;
  logic        [63:0] num5_r, num6_r;
  logic        [63:0] an_nxt;
  logic        [30:0] ad_nxt;

  // divider chain
  logic [30:0] rem_w [btpc_pkg::DivBits+1];
  logic [63:0] dq_w  [btpc_pkg::DivBits+1];
  logic [30:0] dd_w  [btpc_pkg::DivBits+1];
  logic [63:0] an_r;
  logic [30:0] ad_r;

  // post stages
  logic [63:0]        pq_nxt;
  logic [63:0]        p1_r, p2_r, p3_r, p4_r;
  logic [63:0]        ph1_r, ph2_r;
  logic signed [48:0] m1lo, c2lo;
  logic [31:0]        m1hi, c2hi;
  logic [63:0]        m1_r, c2_r;
  logic [63:0]        ll_r;
  logic [31:0]        lh_r, hl_r;
  logic [63:0]        c2s3_r, c2s4_r;
  logic [63:0]        m2;
  logic [63:0]        c1_r;
  logic [63:0]        tsum, rsum;

  logic               out_valid_r;
  btpc_pkg::tinfo_t   out_ti_r;
  logic [31:0]        out_press_r;
  logic               out_zero_r;
  logic [31:0]        press_nxt;

  // the whole back end moves as one; an output stall holds every stage
  assign adv = !out_valid_r || out_bus.ready;
  assign pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[btpc_pkg::BackStages-2:0], pop};
      out_valid_r <= v_r[btpc_pkg::BackStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ti_r[0] <= q_data.ti;
      for (int i = 1; i < btpc_pkg::BackStages; i++) begin
        ti_r[i] <= ti_r[i-1];
      end
      fl_r[btpc_pkg::FlagStart] <= fl_nxt;
      for (int i = btpc_pkg::FlagStart + 1; i < btpc_pkg::BackStages; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  assign xw    = q_data.ti.fine - btpc_pkg::FineOffset;
  assign vprod = $signed(s4_r) * $signed({1'b0, cal.p1});

  assign an_nxt      = num6_r[63] ? (~num6_r + 64'd1) : num6_r;
  assign ad_nxt      = dv6_r[30] ? (~dv6_r + 31'd1) : dv6_r;
  assign fl_nxt.neg  = num6_r[63] ^ dv6_r[30];
  assign fl_nxt.zero = dv6_r == '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      // offset temperature and pressure head room
      x1_r    <= xw[23:0];
      pn1_r   <= btpc_pkg::PressBase - {1'b0, q_data.adc_p};
      // first products
      xx2_r   <= x1_r * x1_r;
      xp5_2_r <= x1_r * $signed(cal.p5);
      xp2_2_r <= x1_r * $signed(cal.p2);
      pn2_r   <= pn1_r;
      // second products
      y6_3_r  <= xx2_r * $signed(cal.p6);
      x3_3_r  <= xx2_r * $signed(cal.p3);
      xp5_3_r <= xp5_2_r;
      xp2_3_r <= xp2_2_r;
      pn3_r   <= pn2_r;
      // offset and sensitivity sums
      y4_r    <= y6_3_r + ({{24{xp5_3_r[39]}}, xp5_3_r} << 17)
               + ({{48{cal.p4[15]}}, cal.p4} << 35);
      s4_r    <= btpc_pkg::Bias47 + {{8{x3_3_r[63]}}, x3_3_r[63:8]}
               + ({{24{xp2_3_r[39]}}, xp2_3_r} << 12);
      pn4_r   <= pn3_r;
      // divisor and raw numerator
      dv5_r   <= vprod[63:33];
      num5_r  <= {12'b0, pn4_r, 31'b0} - y4_r;
      // scale numerator
      num6_r  <= num5_r * {52'b0, btpc_pkg::DivScale};
      dv6_r   <= dv5_r;
      // magnitudes for the divider
      an_r    <= an_nxt;
      ad_r    <= ad_nxt;
    end
  end

  assign rem_w[0] = '0;
  assign dq_w[0]  = an_r;
  assign dd_w[0]  = ad_r;

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < btpc_pkg::DivBits; k++) begin : g_div
    logic [30:0] rem_r;
    logic [63:0] dq_r;
    logic [30:0] dd_r;
    logic [31:0] trial;
    logic        ge;
    logic [31:0] diff;

    assign trial = {rem_w[k], dq_w[k][63]};
    assign ge    = trial >= {1'b0, dd_w[k]};
    assign diff  = trial - {1'b0, dd_w[k]};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r <= ge ? diff[30:0] : trial[30:0];
        dq_r  <= {dq_w[k][62:0], ge};
        dd_r  <= dd_w[k];
      end
    end

    assign rem_w[k+1] = rem_r;
    assign dq_w[k+1]  = dq_r;
    assign dd_w[k+1]  = dd_r;
  end

  assign pq_nxt = fl_r[btpc_pkg::DivEnd].neg ? (~dq_w[btpc_pkg::DivBits] + 64'd1)
                                             : dq_w[btpc_pkg::DivBits];

  // p9 * ph and p8 * p, low 64 bits from two 16x32 partial products each
  assign m1lo = $signed(cal.p9) * $signed({1'b0, ph1_r[31:0]});
  assign m1hi = {{16{cal.p9[15]}}, cal.p9} * ph1_r[63:32];
  assign c2lo = $signed(cal.p8) * $signed({1'b0, p1_r[31:0]});
  assign c2hi = {{16{cal.p8[15]}}, cal.p8} * p1_r[63:32];

  assign m2 = ll_r + {lh_r + hl_r, 32'b0};

  assign tsum = p4_r + c1_r + c2s4_r;
  assign rsum = {{8{tsum[63]}}, tsum[63:8]} + ({{48{cal.p7[15]}}, cal.p7} << 4);

  always_comb begin
    if (fl_r[btpc_pkg::BackStages-1].zero || rsum[63]) begin
      press_nxt = '0;
    end else if (rsum[62:32] != '0) begin
      press_nxt = '1;
    end else begin
      press_nxt = rsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= pq_nxt;
      ph1_r  <= {{13{pq_nxt[63]}}, pq_nxt[63:13]};
      m1_r   <= {{15{m1lo[48]}}, m1lo} + {m1hi, 32'b0};
      c2_r   <= {{15{c2lo[48]}}, c2lo} + {c2hi, 32'b0};
      p2_r   <= p1_r;
      ph2_r  <= ph1_r;
      ll_r   <= m1_r[31:0] * ph2_r[31:0];
      lh_r   <= m1_r[31:0] * ph2_r[63:32];
      hl_r   <= m1_r[63:32] * ph2_r[31:0];
      c2s3_r <= {{19{c2_r[63]}}, c2_r[63:19]};
      p3_r   <= p2_r;
      c1_r   <= {{25{m2[63]}}, m2[63:25]};
      c2s4_r <= c2s3_r;
      p4_r   <= p3_r;
      out_ti_r    <= ti_r[btpc_pkg::BackStages-1];
      out_press_r <= press_nxt;
      out_zero_r  <= fl_r[btpc_pkg::BackStages-1].zero;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.fine_temperature  = out_ti_r.fine;
  assign out_bus.temperature_centi = out_ti_r.centi;
  assign out_bus.pressure_q24_8    = out_press_r;
  assign out_bus.divisor_zero      = out_zero_r;

  a_zero_forces_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_r) |-> out_press_r == '0)
    else $error("pressure not forced to zero on zero divisor");

endmodule

`default_nettype wire

/* src/baro_temp_press_compensation.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake          | Beat contents
// ---------+-----+--------------------+-----------------------------------------------
// in_bus   | in  | valid/ready        | raw_temperature, raw_pressure (20 b each)
// out_bus  | out | valid/ready        | fine_temperature, temperature_centi,
//          |     |                    | pressure_q24_8, divisor_zero
// cfg_*    | in  | cfg_we, no stall   | cfg_index selects calibration word, cfg_data
//
// One beat per cycle sustained while out_bus is ready. Each beat passes the temperature
// front end, then the queue, then the pressure back end; the 64-bit divide spends one
// pipeline stage per quotient bit and makes up most of the back end's depth.
// rst_n (synchronous) zeros all calibration words and empties every stage.
// An out_bus stall freezes the back end only; the front end keeps taking beats
// until the 4-entry queue is full and the front end's last stage holds a beat.

module baro_temp_press_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  btpc_in_if.sink          in_bus,
  btpc_out_if.source       out_bus
);

  logic [47:0] temp_cal_r;
  logic [63:0] press_low_r;
  logic [63:0] press_mid_r;
  logic [15:0] press_top_r;

  btpc_pkg::cal_t cal;
  btpc_pkg::tq_t  push_data, pop_data;
  logic           push, pop, q_nonempty, q_not_full;

  // calibration words; user writes only while pipeline is drained, not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r  <= '0;
      press_low_r <= '0;
      press_mid_r <= '0;
      press_top_r <= '0;
    end else if (cfg_we) begin
      case (btpc_pkg::cfg_idx_t'(cfg_index))
        btpc_pkg::CfgTemp:     temp_cal_r  <= cfg_data[47:0];
        btpc_pkg::CfgPressLow: press_low_r <= cfg_data;
        btpc_pkg::CfgPressMid: press_mid_r <= cfg_data;
        btpc_pkg::CfgPressTop: press_top_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // unpack the twelve coefficients
  assign cal.t1 = temp_cal_r[15:0];
  assign cal.t2 = temp_cal_r[31:16];
  assign cal.t3 = temp_cal_r[47:32];
  assign cal.p1 = press_low_r[15:0];
  assign cal.p2 = press_low_r[31:16];
  assign cal.p3 = press_low_r[47:32];
  assign cal.p4 = press_low_r[63:48];
  assign cal.p5 = press_mid_r[15:0];
  assign cal.p6 = press_mid_r[31:16];
  assign cal.p7 = press_mid_r[47:32];
  assign cal.p8 = press_mid_r[63:48];
  assign cal.p9 = press_top_r;

  // temperature terms, fine value and centidegrees
  btpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cal       (cal),
    .q_ready   (q_not_full),
    .push      (push),
    .push_data (push_data)
  );

  // decouple the two halves so each stalls on its own
  btpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .nonempty  (q_nonempty),
    .not_full  (q_not_full)
  );

  // pressure path: products, pipelined divide, second-order correction, clamp
  btpc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cal     (cal),
    .q_valid (q_nonempty),
    .q_data  (pop_data),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

/* sim/btpc_checker.sv */
`timescale 1ns / 1ps

module btpc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  btpc_in_if          in_mon,
  btpc_out_if         out_mon,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          zero_div_seen
);

  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [15:0] centi;
    logic        [31:0] press;
    logic               zero_div;
  } reading_t;

  logic [47:0] temp_word;
  logic [63:0] press_lo_word;
  logic [63:0] press_mid_word;
  logic [15:0] press_top_word;
  reading_t    expected_readings[$];

  function automatic longint signed div_wrap(longint signed a, longint signed b);
    if (b == -64'sd1) return -a;
    return a / b;
  endfunction

  // Compensate one raw pair with the current calibration
  function automatic reading_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
    btpc_pkg::cal_t cal;
    longint signed  adc_t, adc_p, d1, d2, ta, tb, fine, centi;
    longint signed  x, y, p, ph, c1, c2;
    reading_t       r;
    cal = {temp_word[15:0], temp_word[31:16], temp_word[47:32],
           press_lo_word[15:0], press_lo_word[31:16], press_lo_word[47:32],
           press_lo_word[63:48], press_mid_word[15:0], press_mid_word[31:16],
           press_mid_word[47:32], press_mid_word[63:48], press_top_word};
    adc_t = longint'(raw_t);
    adc_p = longint'(raw_p);
    d1 = (adc_t >>> 3) - 2 * longint'(cal.t1);
    ta = (d1 * longint'(cal.t2)) >>> 11;
    d2 = (adc_t >>> 4) - longint'(cal.t1);
    tb = (((d2 * d2) >>> 12) * longint'(cal.t3)) >>> 14;
    fine = ta + tb;
    centi = (fine * 5 + 128) >>> 8;
    if (centi > 32767) centi = 32767;
    if (centi < -32768) centi = -32768;
    r.fine = fine[31:0];
    r.centi = centi[15:0];

    x = fine - 128000;
    y = x * x * longint'(cal.p6);
    y = y + ((x * longint'(cal.p5)) <<< 17);
    y = y + (longint'(cal.p4) <<< 35);
    x = ((x * x * longint'(cal.p3)) >>> 8) + ((x * longint'(cal.p2)) <<< 12);
    x = (((64'sd1 <<< 47) + x) * longint'(cal.p1)) >>> 33;
    if (x == 0) begin
      r.press = '0;
      r.zero_div = 1'b1;
    end else begin
      p = 1048576 - adc_p;
      p = div_wrap(((p <<< 31) - y) * 3125, x);
      ph = p >>> 13;
      c1 = (longint'(cal.p9) * ph * ph) >>> 25;
      c2 = (longint'(cal.p8) * p) >>> 19;
      p = ((p + c1 + c2) >>> 8) + (longint'(cal.p7) <<< 4);
      if (p < 0) r.press = '0;
      else if (p > 64'sh0000_0000_FFFF_FFFF) r.press = 32'hFFFF_FFFF;
      else r.press = p[31:0];
      r.zero_div = 1'b0;
    end
    return r;
  endfunction

  assign pending = expected_readings.size();

  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst_n) begin
      temp_word <= '0;
      press_lo_word <= '0;
      press_mid_word <= '0;
      press_top_word <= '0;
      errors <= 0;
      results_seen <= 0;
      zero_div_seen <= 0;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        case (btpc_pkg::cfg_idx_t'(cfg_index))
          btpc_pkg::CfgTemp:     temp_word <= cfg_data[47:0];
          btpc_pkg::CfgPressLow: press_lo_word <= cfg_data;
          btpc_pkg::CfgPressMid: press_mid_word <= cfg_data;
          btpc_pkg::CfgPressTop: press_top_word <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_readings.push_back(compensate(in_mon.raw_temperature, in_mon.raw_pressure));
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        if (out_mon.divisor_zero) zero_div_seen <= zero_div_seen + 1;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result beat fine=%0d", $time, out_mon.fine_temperature);
          errors <= errors + 1;
        end else begin
          exp_r = expected_readings.pop_front();
          if (exp_r.fine !== out_mon.fine_temperature ||
              exp_r.centi !== out_mon.temperature_centi ||
              exp_r.press !== out_mon.pressure_q24_8 ||
              exp_r.zero_div !== out_mon.divisor_zero) begin
            $display("%0t: mismatch exp fine=%0d centi=%0d press=%h dz=%b",
                     $time, exp_r.fine, exp_r.centi, exp_r.press, exp_r.zero_div);
            $display("%0t:          got fine=%0d centi=%0d press=%h dz=%b",
                     $time, out_mon.fine_temperature, out_mon.temperature_centi,
                     out_mon.pressure_q24_8, out_mon.divisor_zero);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_baro_temp_press_compensation.sv */
`timescale 1ns / 1ps

module tb_baro_temp_press_compensation;

  localparam int IdleLimit  = 3000;  // cycles with no beat on either side
  localparam int LongHold   = 400;   // receiver hold-off, well past pipeline depth
  localparam int PhaseItems = 160;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  int          errors, pending, results_seen, zero_div_seen;
  int          items_sent;

  btpc_in_if  in_bus ();
  btpc_out_if out_bus ();

  baro_temp_press_compensation u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_bus(in_bus), .out_bus(out_bus)
  );

  btpc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_mon(in_bus), .out_mon(out_bus), .errors(errors),
    .pending(pending), .results_seen(results_seen), .zero_div_seen(zero_div_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long; mode 0 means no idling
  function automatic int gap_len(bit busy_mode);
    int r;
    if (!busy_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, one long hold-off after a few hundred results
  bit sink_busy_mode;
  int sink_gap;
  int hold_left;
  bit long_hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_gap <= 0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
      sink_busy_mode <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 300) begin
      long_hold_done <= 1'b1;
      hold_left <= LongHold;
      out_bus.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if (out_bus.valid && out_bus.ready) begin
        sink_gap <= gap_len(sink_busy_mode);
        // switch between idling and back-to-back stretches now and then
        if ($urandom_range(0, 99) == 0) sink_busy_mode <= ~sink_busy_mode;
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
      $display("Verification failed");
      $finish;
    end
  end

  bit src_busy_mode;

  // Offer one beat and hold it until accepted; drop valid after the last beat or before a gap
  task automatic send_reading(logic [19:0] raw_t, logic [19:0] raw_p, bit last_in_burst);
    int gap;
    in_bus.valid <= 1'b1;
    in_bus.raw_temperature <= raw_t;
    in_bus.raw_pressure <= raw_p;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    gap = gap_len(src_busy_mode);
    if (gap > 0 || last_in_burst) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected result is back, so calibration can change
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four calibration words back to back, then drop the enable
  task automatic load_calibration(logic [47:0] tw, logic [63:0] lo, logic [63:0] mid,
                                  logic [15:0] top);
    cfg_we <= 1'b1;
    cfg_index <= btpc_pkg::CfgTemp;     cfg_data <= {16'h0, tw};   @(posedge clk);
    cfg_index <= btpc_pkg::CfgPressLow; cfg_data <= lo;            @(posedge clk);
    cfg_index <= btpc_pkg::CfgPressMid; cfg_data <= mid;           @(posedge clk);
    cfg_index <= btpc_pkg::CfgPressTop; cfg_data <= {48'h0, top};  @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_burst(int n);
    logic [19:0] rt, rp;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 60) begin
        // plausible sensor range, where the compensation is well behaved
        rt = 20'($urandom_range(400000, 600000));
        rp = 20'($urandom_range(200000, 650000));
      end else begin
        rt = 20'($urandom);
        rp = 20'($urandom);
      end
      if ($urandom_range(0, 199) == 0) src_busy_mode = ~src_busy_mode;
      send_reading(rt, rp, i == n - 1);
    end
  endtask

  task automatic directed_corners();
    send_reading(20'h00000, 20'h00000, 1'b0);
    send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_reading(20'h00000, 20'hFFFFF, 1'b0);
    send_reading(20'hFFFFF, 20'h00000, 1'b0);
    send_reading(20'd519888, 20'd415148, 1'b0);
    send_reading(20'h80000, 20'h7FFFF, 1'b1);
  endtask

  // Typical factory calibration of this sensor family
  localparam logic [47:0] TypTemp = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TypLow  = {16'd2855, 16'd3024, 16'hD443, 16'd36477};
  localparam logic [63:0] TypMid  = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [15:0] TypTop  = 16'd6000;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = btpc_pkg::CfgTemp;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.raw_temperature = '0;
    in_bus.raw_pressure = '0;
    items_sent = 0;
    src_busy_mode = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: divisor is always zero
    directed_corners();
    drain();
    load_calibration(TypTemp, TypLow, TypMid, TypTop);
    directed_corners();
    drain();
    // all-ones words, then most negative and most positive coefficients
    load_calibration('1, '1, '1, '1);
    directed_corners();
    drain();
    load_calibration({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
    directed_corners();
    drain();
    load_calibration({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
    random_burst(PhaseItems);
    drain();

    // back to typical, long random run covers the receiver hold-off
    load_calibration(TypTemp, TypLow, TypMid, TypTop);
    random_burst(2 * PhaseItems);
    drain();

    // zero P1 forces a zero divisor with random other coefficients
    load_calibration(48'({$urandom, $urandom}), {48'({$urandom, $urandom}), 16'h0},
                     {$urandom, $urandom}, 16'($urandom));
    random_burst(PhaseItems / 2);
    drain();

    // fully random calibration sets
    for (int k = 0; k < 3; k++) begin
      load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                       {$urandom, $urandom}, 16'($urandom));
      random_burst(PhaseItems);
      drain();
    end

    // typical temperature with perturbed pressure terms
    load_calibration(TypTemp, TypLow ^ 64'($urandom_range(0, 255)),
                     TypMid ^ {16'($urandom), 48'h0}, 16'($urandom));
    random_burst(PhaseItems);
    drain();

    repeat (100) @(posedge clk);
    $display("Sent %0d readings over 11 calibration sets, %0d results checked,",
             items_sent, results_seen);
    $display("%0d with zero divisor, %0d still outstanding", zero_div_seen, pending);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* baro_temp_press_compensation.f */
src/btpc_pkg.sv
src/btpc_in_if.sv
src/btpc_out_if.sv
src/btpc_front.sv
src/btpc_queue.sv
src/btpc_back.sv
src/baro_temp_press_compensation.sv
sim/btpc_checker.sv
sim/tb_baro_temp_press_compensation.sv
